[rtl/ga2d_pkg.sv]
// shared widths, opcodes and saturation limits for the 2d multivector alu
`timescale 1ns / 1ps
`default_nettype none
package ga2d_pkg;

  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 12;

  // full product and four-term sum widths
  localparam int PROD_W = 2 * WORD_BITS;
  localparam int GROW_W = 2 * WORD_BITS + 2;
  localparam int LIN_W  = WORD_BITS + 2 + FRAC_BITS;
  localparam int SUM_W  = (GROW_W > LIN_W) ? GROW_W : LIN_W;
  localparam int SH_W   = SUM_W - FRAC_BITS;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_NEG  = 4'd2;
  localparam logic [3:0] OP_REV  = 4'd3;
  localparam logic [3:0] OP_GEO  = 4'd4;
  localparam logic [3:0] OP_OUT  = 4'd5;
  localparam logic [3:0] OP_INN  = 4'd6;
  localparam logic [3:0] OP_LCON = 4'd7;
  localparam logic [3:0] OP_RCON = 4'd8;

  // component order inside a multivector
  localparam int C_S   = 0;
  localparam int C_E1  = 1;
  localparam int C_E2  = 2;
  localparam int C_E12 = 3;

endpackage
`default_nettype wire

[rtl/ga2d_multivector_alu.sv]
// ga2d_multivector_alu: three-stage pipelined alu for cl(2,0) multivectors
// an accepted input transaction passes the stage 1, stage 2 and output registers on its way to out_valid
// throughput: one transaction per cycle while the output is not stalled; the sixteen 16x16
// multipliers of the first stage then take a new operand pair every clock
// a stall on a valid output freezes all three stages together, in_stall follows it
// reset (rst_n low, synchronous) empties the pipeline; payload is not cleared
`timescale 1ns / 1ps
`default_nettype none
module ga2d_multivector_alu
  import ga2d_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [3:0]                  in_req_type,
  input  wire logic signed [WORD_BITS-1:0] in_first_scalar,
  input  wire logic signed [WORD_BITS-1:0] in_first_e1,
  input  wire logic signed [WORD_BITS-1:0] in_first_e2,
  input  wire logic signed [WORD_BITS-1:0] in_first_e12,
  input  wire logic signed [WORD_BITS-1:0] in_second_scalar,
  input  wire logic signed [WORD_BITS-1:0] in_second_e1,
  input  wire logic signed [WORD_BITS-1:0] in_second_e2,
  input  wire logic signed [WORD_BITS-1:0] in_second_e12,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [WORD_BITS-1:0]      out_scalar,
  output logic signed [WORD_BITS-1:0]      out_e1,
  output logic signed [WORD_BITS-1:0]      out_e2,
  output logic signed [WORD_BITS-1:0]      out_e12,
  output logic                             out_overflow
);

  // pipeline advance: moves unless a finished result is held by the sink
  logic en;

  // input operands as small arrays, indexed by component
  logic signed [WORD_BITS-1:0] a_in [4];
  logic signed [WORD_BITS-1:0] b_in [4];

  // stage 1: operands and all sixteen partial products
  logic                        v1_r;
  logic [3:0]                  op1_r;
  logic signed [WORD_BITS-1:0] a1_r [4];
  logic signed [WORD_BITS-1:0] b1_r [4];
  logic signed [PROD_W-1:0]    prod_nxt [4][4];
  logic signed [PROD_W-1:0]    prod_r [4][4];

  // stage 2: per-part signed sums
  logic                        v2_r;
  logic signed [SUM_W-1:0]     pe [4][4];
  logic signed [SUM_W-1:0]     la [4];
  logic signed [SUM_W-1:0]     lb [4];
  logic signed [SUM_W-1:0]     dot;
  logic signed [SUM_W-1:0]     sum_nxt [4];
  logic signed [SUM_W-1:0]     sum_r [4];

  // stage 3: shift, saturate, output register
  logic [SH_W-1:0]             shr [4];
  logic [SH_W-WORD_BITS:0]     top [4];
  logic [WORD_BITS-1:0]        res_nxt [4];
  logic                        ovf_nxt;
  logic                        out_valid_r;
  logic [WORD_BITS-1:0]        res_r [4];
  logic                        ovf_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign a_in[C_S]   = in_first_scalar;
  assign a_in[C_E1]  = in_first_e1;
  assign a_in[C_E2]  = in_first_e2;
  assign a_in[C_E12] = in_first_e12;
  assign b_in[C_S]   = in_second_scalar;
  assign b_in[C_E1]  = in_second_e1;
  assign b_in[C_E2]  = in_second_e2;
  assign b_in[C_E12] = in_second_e12;

  // ---------------- stage 1: multiply ----------------
  // product [i][j] is component i of a times component j of b
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_nxt[i][j] = a_in[i] * b_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= in_req_type;
      a1_r   <= a_in;
      b1_r   <= b_in;
      prod_r <= prod_nxt;
    end
  end

  // ---------------- stage 2: select and sum ----------------
  // linear ops are carried pre-scaled by the fraction shift, so the common
  // arithmetic shift in stage 3 hands them back unchanged
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      la[i] = SUM_W'(a1_r[i]) <<< FRAC_BITS;
      lb[i] = SUM_W'(b1_r[i]) <<< FRAC_BITS;
      for (int j = 0; j < 4; j++) begin
        pe[i][j] = SUM_W'(prod_r[i][j]);
      end
    end
  end

  // scalar part shared by geometric, inner and both contractions
  assign dot = pe[C_S][C_S] + pe[C_E1][C_E1] + pe[C_E2][C_E2] - pe[C_E12][C_E12];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_nxt[k] = '0;
    end
    case (op1_r)
      OP_ADD: begin
        for (int k = 0; k < 4; k++) begin
          sum_nxt[k] = la[k] + lb[k];
        end
      end
      OP_SUB: begin
        for (int k = 0; k < 4; k++) begin
          sum_nxt[k] = la[k] - lb[k];
        end
      end
      OP_NEG: begin
        for (int k = 0; k < 4; k++) begin
          sum_nxt[k] = -la[k];
        end
      end
      OP_REV: begin
        sum_nxt[C_S]   = la[C_S];
        sum_nxt[C_E1]  = la[C_E1];
        sum_nxt[C_E2]  = la[C_E2];
        sum_nxt[C_E12] = -la[C_E12];
      end
      OP_GEO: begin
        sum_nxt[C_S]   = dot;
        sum_nxt[C_E1]  = pe[C_S][C_E1] + pe[C_E1][C_S]
                       - pe[C_E2][C_E12] + pe[C_E12][C_E2];
        sum_nxt[C_E2]  = pe[C_S][C_E2] + pe[C_E2][C_S]
                       + pe[C_E1][C_E12] - pe[C_E12][C_E1];
        sum_nxt[C_E12] = pe[C_S][C_E12] + pe[C_E12][C_S]
                       + pe[C_E1][C_E2] - pe[C_E2][C_E1];
      end
      OP_OUT: begin
        sum_nxt[C_S]   = pe[C_S][C_S];
        sum_nxt[C_E1]  = pe[C_E1][C_S] + pe[C_S][C_E1];
        sum_nxt[C_E2]  = pe[C_S][C_E2] + pe[C_E2][C_S];
        sum_nxt[C_E12] = pe[C_E12][C_S] + pe[C_S][C_E12]
                       + pe[C_E1][C_E2] - pe[C_E2][C_E1];
      end
      OP_INN: begin
        sum_nxt[C_S] = dot;
      end
      OP_LCON: begin
        sum_nxt[C_S]   = dot;
        sum_nxt[C_E1]  = pe[C_S][C_E1] - pe[C_E2][C_E12];
        sum_nxt[C_E2]  = pe[C_S][C_E2] + pe[C_E1][C_E12];
        sum_nxt[C_E12] = pe[C_S][C_E12];
      end
      OP_RCON: begin
        sum_nxt[C_S]   = dot;
        sum_nxt[C_E1]  = pe[C_E1][C_S] + pe[C_E12][C_E2];
        sum_nxt[C_E2]  = pe[C_E2][C_S] - pe[C_E12][C_E1];
        sum_nxt[C_E12] = pe[C_E12][C_S];
      end
      default: begin
        // unused opcodes give an all-zero result without overflow
        for (int k = 0; k < 4; k++) begin
          sum_nxt[k] = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  // ---------------- stage 3: shift and saturate ----------------
  // dropping the fraction bits is an arithmetic shift (floor); a part fits
  // when every bit from the word's sign bit upward agrees
  always_comb begin
    ovf_nxt = 1'b0;
    for (int k = 0; k < 4; k++) begin
      shr[k] = sum_r[k][SUM_W-1:FRAC_BITS];
      top[k] = shr[k][SH_W-1:WORD_BITS-1];
      if ((&top[k]) || !(|top[k])) begin
        res_nxt[k] = shr[k][WORD_BITS-1:0];
      end else begin
        res_nxt[k] = shr[k][SH_W-1] ? WORD_MIN : WORD_MAX;
        ovf_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_scalar   = res_r[C_S];
  assign out_e1       = res_r[C_E1];
  assign out_e2       = res_r[C_E2];
  assign out_e12      = res_r[C_E12];
  assign out_overflow = ovf_r;

`ifndef ASSERT_OFF
  // the input side is held off exactly while a finished result is stalled
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid_r && out_stall))
    else $error("in_stall does not follow the output stall");

  // reset leaves the pipeline empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !v2_r && !v1_r)
    else $error("pipeline not empty after reset");

  // a stalled output freezes the inner stages as well
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(v1_r) && $stable(v2_r))
    else $error("inner stage moved during an output stall");

  // overflow is only reported with at least one part at a saturation limit
  a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ovf_r |->
      res_r[C_S] == WORD_MAX || res_r[C_S] == WORD_MIN ||
      res_r[C_E1] == WORD_MAX || res_r[C_E1] == WORD_MIN ||
      res_r[C_E2] == WORD_MAX || res_r[C_E2] == WORD_MIN ||
      res_r[C_E12] == WORD_MAX || res_r[C_E12] == WORD_MIN)
    else $error("overflow flagged without a saturated part");
`endif

endmodule
`default_nettype wire

[sim/ga2d_multivector_alu_test.sv]
// self-checking testbench for the 2d multivector alu: directed table then random traffic
`timescale 1ns / 1ps
module ga2d_multivector_alu_test;
  import ga2d_pkg::*;

  // opcodes past the last operation give an all-zero result
  localparam logic [3:0] OP_UNUSED_LO = 4'd9;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;
  localparam logic signed [WORD_BITS-1:0] UNIT = WORD_BITS'(1 <<< FRAC_BITS);
  // longest run with no transaction on either port before the run is declared hung
  localparam int HANG_LIMIT = 4000;
  // pipeline depth plus margin, waited out once the last result is in
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1150;

  // one multivector, scalar part in the top bits
  typedef struct packed {
    logic signed [WORD_BITS-1:0] s;
    logic signed [WORD_BITS-1:0] e1;
    logic signed [WORD_BITS-1:0] e2;
    logic signed [WORD_BITS-1:0] e12;
  } mv_t;

  typedef struct packed {
    logic [3:0] op;
    mv_t a;
    mv_t b;
  } req_t;

  typedef struct packed {
    mv_t mv;
    logic ovf;
  } res_t;

  // directed row: the result is typed in only where it is obvious
  typedef struct {
    req_t req;
    bit typed;
    res_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [3:0] in_req_type;
  logic signed [WORD_BITS-1:0] in_first_scalar;
  logic signed [WORD_BITS-1:0] in_first_e1;
  logic signed [WORD_BITS-1:0] in_first_e2;
  logic signed [WORD_BITS-1:0] in_first_e12;
  logic signed [WORD_BITS-1:0] in_second_scalar;
  logic signed [WORD_BITS-1:0] in_second_e1;
  logic signed [WORD_BITS-1:0] in_second_e2;
  logic signed [WORD_BITS-1:0] in_second_e12;
  logic out_valid;
  logic out_stall;
  logic signed [WORD_BITS-1:0] out_scalar;
  logic signed [WORD_BITS-1:0] out_e1;
  logic signed [WORD_BITS-1:0] out_e2;
  logic signed [WORD_BITS-1:0] out_e12;
  logic out_overflow;

  res_t pending_results[$];
  row_t directed_rows[$];
  int error_count = 0;
  int result_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 31;
  int recv_idle_pct = 56;
  // expectation override for the transaction currently on the input port
  bit cur_typed = 1'b0;
  res_t cur_want = '0;
  string part_name[4] = '{"scalar", "e1", "e2", "e12"};

  ga2d_multivector_alu DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_first_scalar  (in_first_scalar),
    .in_first_e1      (in_first_e1),
    .in_first_e2      (in_first_e2),
    .in_first_e12     (in_first_e12),
    .in_second_scalar (in_second_scalar),
    .in_second_e1     (in_second_e1),
    .in_second_e2     (in_second_e2),
    .in_second_e12    (in_second_e12),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scalar       (out_scalar),
    .out_e1           (out_e1),
    .out_e2           (out_e2),
    .out_e12          (out_e12),
    .out_overflow     (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // shift a full-width sum down, then clamp to the word range
  function automatic logic signed [WORD_BITS-1:0] clamp_part(input longint sum, input int sh,
                                                             inout bit ov);
    longint v;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    lo = -hi - 1;
    v = sum >>> sh;
    if (v > hi) begin
      ov = 1'b1;
      return WORD_MAX;
    end
    if (v < lo) begin
      ov = 1'b1;
      return WORD_MIN;
    end
    return v[WORD_BITS-1:0];
  endfunction

  // expected multivector and overflow flag for one request
  function automatic res_t mv_result(input req_t r);
    longint a, x, y, b, a2, x2, y2, b2;
    longint dot;
    bit ov;
    res_t res;
    a = $signed(r.a.s);
    x = $signed(r.a.e1);
    y = $signed(r.a.e2);
    b = $signed(r.a.e12);
    a2 = $signed(r.b.s);
    x2 = $signed(r.b.e1);
    y2 = $signed(r.b.e2);
    b2 = $signed(r.b.e12);
    ov = 1'b0;
    res = '0;
    dot = a * a2 + x * x2 + y * y2 - b * b2;
    case (r.op)
      OP_ADD: begin
        res.mv.s   = clamp_part(a + a2, 0, ov);
        res.mv.e1  = clamp_part(x + x2, 0, ov);
        res.mv.e2  = clamp_part(y + y2, 0, ov);
        res.mv.e12 = clamp_part(b + b2, 0, ov);
      end
      OP_SUB: begin
        res.mv.s   = clamp_part(a - a2, 0, ov);
        res.mv.e1  = clamp_part(x - x2, 0, ov);
        res.mv.e2  = clamp_part(y - y2, 0, ov);
        res.mv.e12 = clamp_part(b - b2, 0, ov);
      end
      OP_NEG: begin
        res.mv.s   = clamp_part(-a, 0, ov);
        res.mv.e1  = clamp_part(-x, 0, ov);
        res.mv.e2  = clamp_part(-y, 0, ov);
        res.mv.e12 = clamp_part(-b, 0, ov);
      end
      OP_REV: begin
        res.mv.s   = clamp_part(a, 0, ov);
        res.mv.e1  = clamp_part(x, 0, ov);
        res.mv.e2  = clamp_part(y, 0, ov);
        res.mv.e12 = clamp_part(-b, 0, ov);
      end
      OP_GEO: begin
        res.mv.s   = clamp_part(dot, FRAC_BITS, ov);
        res.mv.e1  = clamp_part(a * x2 + x * a2 - y * b2 + b * y2, FRAC_BITS, ov);
        res.mv.e2  = clamp_part(a * y2 + y * a2 + x * b2 - b * x2, FRAC_BITS, ov);
        res.mv.e12 = clamp_part(a * b2 + b * a2 + x * y2 - y * x2, FRAC_BITS, ov);
      end
      OP_OUT: begin
        res.mv.s   = clamp_part(a * a2, FRAC_BITS, ov);
        res.mv.e1  = clamp_part(x * a2 + a * x2, FRAC_BITS, ov);
        res.mv.e2  = clamp_part(a * y2 + y * a2, FRAC_BITS, ov);
        res.mv.e12 = clamp_part(b * a2 + a * b2 + x * y2 - y * x2, FRAC_BITS, ov);
      end
      OP_INN: begin
        res.mv.s = clamp_part(dot, FRAC_BITS, ov);
      end
      OP_LCON: begin
        res.mv.s   = clamp_part(dot, FRAC_BITS, ov);
        res.mv.e1  = clamp_part(a * x2 - y * b2, FRAC_BITS, ov);
        res.mv.e2  = clamp_part(a * y2 + x * b2, FRAC_BITS, ov);
        res.mv.e12 = clamp_part(a * b2, FRAC_BITS, ov);
      end
      OP_RCON: begin
        res.mv.s   = clamp_part(dot, FRAC_BITS, ov);
        res.mv.e1  = clamp_part(x * a2 + b * y2, FRAC_BITS, ov);
        res.mv.e2  = clamp_part(y * a2 - b * x2, FRAC_BITS, ov);
        res.mv.e12 = clamp_part(b * a2, FRAC_BITS, ov);
      end
      default: begin
      end
    endcase
    res.ovf = ov;
    return res;
  endfunction

  function automatic mv_t mv_of(input int s, input int e1, input int e2, input int e12);
    mv_t m;
    m.s = s[WORD_BITS-1:0];
    m.e1 = e1[WORD_BITS-1:0];
    m.e2 = e2[WORD_BITS-1:0];
    m.e12 = e12[WORD_BITS-1:0];
    return m;
  endfunction

  task automatic add_row(input logic [3:0] op, input mv_t a, input mv_t b, input bit typed,
                         input mv_t want_mv, input bit want_ov);
    row_t row;
    row.req = '{op: op, a: a, b: b};
    row.typed = typed;
    row.want = '{mv: want_mv, ovf: want_ov};
    directed_rows.push_back(row);
  endtask

  // one part of a random operand, weighted toward the interesting magnitudes
  function automatic logic signed [WORD_BITS-1:0] rand_part(input int mode);
    logic signed [WORD_BITS-1:0] pick;
    int sel;
    sel = (mode == 2) ? $urandom_range(0, 9) : mode * 4;
    case (sel)
      0, 1, 2, 3: pick = WORD_BITS'($signed($urandom_range(0, 2 * UNIT)) - UNIT);
      4, 5, 6: pick = WORD_BITS'($urandom);
      7: pick = WORD_BITS'($signed($urandom_range(0, 32)) - 16);
      default: begin
        case ($urandom_range(0, 5))
          0: pick = WORD_MAX;
          1: pick = WORD_MIN;
          2: pick = '0;
          3: pick = '1;
          4: pick = UNIT;
          default: pick = -UNIT;
        endcase
      end
    endcase
    return pick;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int mode;
    // mostly well-scaled operands so that products stay in range, some full-scale
    mode = $urandom_range(0, 3);
    mode = (mode == 3) ? 1 : (mode == 2) ? 2 : 0;
    if ($urandom_range(0, 99) < 94)
      r.op = 4'($urandom_range(OP_ADD, OP_RCON));
    else
      r.op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    r.a = '{rand_part(mode), rand_part(mode), rand_part(mode), rand_part(mode)};
    r.b = '{rand_part(mode), rand_part(mode), rand_part(mode), rand_part(mode)};
    return r;
  endfunction

  // present one transaction, with a random gap ahead of it; called at a falling edge
  task automatic send_item(input req_t r, input bit typed, input res_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.op;
    in_first_scalar <= r.a.s;
    in_first_e1 <= r.a.e1;
    in_first_e2 <= r.a.e2;
    in_first_e12 <= r.a.e12;
    in_second_scalar <= r.b.s;
    in_second_e1 <= r.b.e1;
    in_second_e2 <= r.b.e2;
    in_second_e12 <= r.b.e12;
    cur_typed = typed;
    cur_want = want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // receiver back-pressure, redrawn every cycle
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // scoreboard and hang watchdog, all sampled at the rising edge
  always @(posedge clk) begin
    res_t got;
    res_t want;
    req_t seen;
    bit took;
    if (rst_n) begin
      took = 1'b0;
      if (in_valid && !in_stall) begin
        seen.op = in_req_type;
        seen.a = '{in_first_scalar, in_first_e1, in_first_e2, in_first_e12};
        seen.b = '{in_second_scalar, in_second_e1, in_second_e2, in_second_e12};
        pending_results.push_back(cur_typed ? cur_want : mv_result(seen));
        took = 1'b1;
      end
      if (out_valid && !out_stall) begin
        took = 1'b1;
        got = '{mv: '{out_scalar, out_e1, out_e2, out_e12}, ovf: out_overflow};
        if (pending_results.size() == 0) begin
          report($sformatf("result %0d arrived with nothing outstanding", result_count));
        end else begin
          want = pending_results.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got.mv[WORD_BITS*(3-k) +: WORD_BITS] !== want.mv[WORD_BITS*(3-k) +: WORD_BITS])
              report($sformatf("result %0d %s got %0d want %0d", result_count, part_name[k],
                               $signed(got.mv[WORD_BITS*(3-k) +: WORD_BITS]),
                               $signed(want.mv[WORD_BITS*(3-k) +: WORD_BITS])));
          end
          if (got.ovf !== want.ovf)
            report($sformatf("result %0d overflow got %b want %b", result_count, got.ovf,
                             want.ovf));
        end
        result_count++;
      end
      quiet_cycles = took ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", HANG_LIMIT);
        $display("FAIL ga2d_multivector_alu");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    mv_t zero;
    mv_t top;
    mv_t bot;
    mv_t mix_a;
    mv_t mix_b;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_first_scalar = '0;
    in_first_e1 = '0;
    in_first_e2 = '0;
    in_first_e12 = '0;
    in_second_scalar = '0;
    in_second_e1 = '0;
    in_second_e2 = '0;
    in_second_e12 = '0;

    zero = '0;
    top = '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX};
    bot = '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN};
    mix_a = mv_of(3000, -1500, 2048, -700);
    mix_b = mv_of(-2500, 4000, -1234, 3333);

    // linear operations at the edges of the word
    add_row(OP_ADD, zero, zero, 1'b1, zero, 1'b0);
    add_row(OP_ADD, top, top, 1'b1, top, 1'b1);
    add_row(OP_ADD, bot, bot, 1'b1, bot, 1'b1);
    add_row(OP_SUB, top, bot, 1'b1, top, 1'b1);
    add_row(OP_SUB, bot, top, 1'b1, bot, 1'b1);
    add_row(OP_SUB, mix_a, mix_a, 1'b1, zero, 1'b0);
    // negating the most negative value saturates; operand b is ignored
    add_row(OP_NEG, bot, top, 1'b1, top, 1'b1);
    add_row(OP_NEG, top, bot, 1'b1, mv_of(-32767, -32767, -32767, -32767), 1'b0);
    add_row(OP_REV, mv_of(1, 2, 3, -32768), top, 1'b1, mv_of(1, 2, 3, 32767), 1'b1);
    add_row(OP_REV, mix_a, mix_b, 1'b0, zero, 1'b0);
    // products: unit values, basis blades, rounding toward minus infinity, saturation
    add_row(OP_GEO, mv_of(UNIT, 0, 0, 0), mv_of(UNIT, 0, 0, 0), 1'b0, zero, 1'b0);
    add_row(OP_GEO, mv_of(0, UNIT, 0, 0), mv_of(0, 0, UNIT, 0), 1'b0, zero, 1'b0);
    add_row(OP_GEO, mv_of(-1, 0, 0, -1), mv_of(1, 1, 1, 1), 1'b0, zero, 1'b0);
    add_row(OP_GEO, bot, bot, 1'b0, zero, 1'b0);
    add_row(OP_GEO, top, top, 1'b0, zero, 1'b0);
    add_row(OP_OUT, mix_a, mix_b, 1'b0, zero, 1'b0);
    add_row(OP_OUT, top, bot, 1'b0, zero, 1'b0);
    add_row(OP_INN, mix_a, mix_b, 1'b0, zero, 1'b0);
    add_row(OP_INN, bot, bot, 1'b0, zero, 1'b0);
    add_row(OP_LCON, mix_a, mix_b, 1'b0, zero, 1'b0);
    add_row(OP_LCON, top, bot, 1'b0, zero, 1'b0);
    add_row(OP_RCON, mix_b, mix_a, 1'b0, zero, 1'b0);
    add_row(OP_RCON, bot, top, 1'b0, zero, 1'b0);
    // unused opcodes give zero with no overflow
    add_row(OP_UNUSED_LO, top, top, 1'b1, zero, 1'b0);
    add_row(OP_UNUSED_HI, bot, bot, 1'b1, zero, 1'b0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    // random traffic in three idling phases: receiver-heavy gaps, swapped, then none
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 31;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_item(rand_req(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS ga2d_multivector_alu");
    end else begin
      $display("FAIL ga2d_multivector_alu");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ga2d_pkg.sv
rtl/ga2d_multivector_alu.sv
sim/ga2d_multivector_alu_test.sv
